// File: src/scs_pkg.sv
// Shared types and constants for the swept box collision block.
// Used by scs_div, scs_dp, scs_ctrl and swept_box_collision_slide.
package scs_pkg;

	localparam int MAX_BOXES = 32;
	localparam int IDX_W     = $clog2(MAX_BOXES);
	localparam int CNT_W     = $clog2(MAX_BOXES + 1);
	localparam int NUDGE     = 66;
	localparam int TIME_ONE  = 65536;
	localparam int TIME_SAT  = 1048576;
	localparam int TIME_W    = 22;            // signed slab time, Q.16, +-16.0
	localparam int NUM_W     = 35;            // bound minus origin
	localparam int QBITS     = 21;            // quotient bits before saturation
	localparam int MUL_W     = 32 + TIME_W;
	localparam int SUM_W     = 40;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_BADID = 2'd2;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0]        hw;
		logic [30:0]        hh;
	} box_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_CREATE, OP_REJ_FULL, OP_REJ_ID, OP_RD_ID, OP_LD_ID,
		OP_RD_J, OP_CALC, OP_DIV_GO, OP_EVAL, OP_MUL_N, OP_RES, OP_MUL_R, OP_SLIDE,
		OP_FIN
	} dp_op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_CREATE, S_REJ_FULL, S_REJ_ID, S_RD_ID, S_LD_ID, S_RD_J,
		S_CALC, S_DGO, S_DWAIT, S_EVAL, S_MUL_N, S_RES, S_MUL_R, S_SLIDE, S_FIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic is_create;
		logic full;
		logic id_bad;
		logic div_done;
		logic last_j;
		logic hit;
		logic pass2;
	} dp_status_t;

	function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(64'sd2147483647);
		lo = -SUM_W'(64'sd2147483648);
		if (v > hi) return 32'sh7fffffff;
		if (v < lo) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

// File: src/scs_div.sv
// Iterative signed divider for slab times: (num * 65536) / den, truncated,
// saturated to +-TIME_SAT. One quotient bit a cycle. Depends on scs_pkg.
module scs_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [scs_pkg::NUM_W-1:0]  num,
	input  logic signed [31:0]                den,
	output logic                              done,
	output logic signed [scs_pkg::TIME_W-1:0] quo
);

	localparam int FULL_W = scs_pkg::NUM_W + 16;

	logic [scs_pkg::NUM_W-1:0] mag_n;
	logic [FULL_W-1:0]         full;
	logic [31:0]               mag_d;
	logic [31:0]               rem_q;
	logic [31:0]               d_q;
	logic [scs_pkg::QBITS-1:0] sh_q;
	logic [scs_pkg::QBITS-1:0] q_q;
	logic [4:0]                cnt_q;
	logic                      run_q;
	logic                      done_q;
	logic                      neg_q;
	logic                      sat_q;
	logic [32:0]               r2;
	logic                      ge;
	logic [31:0]               rem_init;
	logic [scs_pkg::QBITS-1:0] qm;
	logic [scs_pkg::QBITS-1:0] sat_c;

	assign mag_n    = num[scs_pkg::NUM_W-1] ? scs_pkg::NUM_W'(-num) : scs_pkg::NUM_W'(num);
	assign full     = {mag_n, 16'd0};
	assign mag_d    = den[31] ? 32'(-den) : 32'(den);
	assign rem_init = 32'(full[FULL_W-1:scs_pkg::QBITS]);
	assign r2       = {rem_q, sh_q[scs_pkg::QBITS-1]};
	assign ge       = r2 >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'(scs_pkg::QBITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			d_q   <= mag_d;
			sh_q  <= full[scs_pkg::QBITS-1:0];
			q_q   <= '0;
			neg_q <= num[scs_pkg::NUM_W-1] ^ den[31];
			sat_q <= rem_init >= mag_d;
		end else if (run_q) begin
			rem_q <= ge ? 32'(r2 - {1'b0, d_q}) : r2[31:0];
			sh_q  <= {sh_q[scs_pkg::QBITS-2:0], 1'b0};
			q_q   <= {q_q[scs_pkg::QBITS-2:0], ge};
		end
	end

	assign sat_c = scs_pkg::QBITS'(scs_pkg::TIME_SAT);
	assign qm    = (sat_q || q_q > sat_c) ? sat_c : q_q;
	assign quo   = neg_q ? -scs_pkg::TIME_W'({1'b0, qm}) : scs_pkg::TIME_W'({1'b0, qm});
	assign done  = done_q;

endmodule

// File: src/scs_dp.sv
// Datapath: box table, slab dividers, earliest-hit tracking, nudge and slide.
// Driven by op codes from scs_ctrl. Depends on scs_pkg and scs_div.
module scs_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  scs_pkg::dp_op_t             op,
	output scs_pkg::dp_status_t         st,
	input  logic                        req_type,
	input  logic [4:0]                  collider_id,
	input  logic signed [31:0]          pos_x,
	input  logic signed [31:0]          pos_y,
	input  logic [30:0]                 half_w,
	input  logic [30:0]                 half_h,
	input  logic signed [31:0]          delta_x,
	input  logic signed [31:0]          delta_y,
	output logic [1:0]                  status,
	output logic [4:0]                  new_id,
	output logic                        collided,
	output logic                        inside_box,
	output logic [4:0]                  hit_id,
	output logic [16:0]                 hit_fraction,
	output logic signed [31:0]          resolved_x,
	output logic signed [31:0]          resolved_y
);

	localparam int TW = scs_pkg::TIME_W;
	localparam int NW = scs_pkg::NUM_W;
	localparam int IW = scs_pkg::IDX_W;
	localparam int CW = scs_pkg::CNT_W;
	localparam int MW = scs_pkg::MUL_W;
	localparam int SW = scs_pkg::SUM_W;

	scs_pkg::box_t boxes [scs_pkg::MAX_BOXES];
	scs_pkg::box_t rd_q;
	logic [IW-1:0] rd_addr;

	logic               req_q;
	logic [4:0]         id_q;
	logic signed [31:0] px_q, py_q, dx_q, dy_q;
	logic [30:0]        hw_in_q, hh_in_q;
	logic [CW-1:0]      count_q;
	logic [30:0]        mv_hw_q, mv_hh_q;
	logic signed [31:0] ox_q, oy_q, ddx_q, ddy_q;
	logic [IW-1:0]      j_q;
	logic signed [TW-1:0] best_q;
	logic               hit_q, inside_q, facex_q, pass2_q;
	logic [IW-1:0]      other_q, p1_other_q;
	logic signed [NW-1:0] nlo_x_q, nhi_x_q, nlo_y_q, nhi_y_q;
	logic signed [MW-1:0] prod_x_q, prod_y_q;
	logic signed [31:0] res_x_q, res_y_q;

	logic               dv_start;
	logic [3:0]         dv_done;
	logic signed [TW-1:0] q_lo_x, q_hi_x, q_lo_y, q_hi_y;

	logic [31:0]        hx, hy;
	logic signed [NW-1:0] lo_x, hi_x, lo_y, hi_y, o_x, o_y;
	logic signed [TW-1:0] sat_p, sat_m, ex, lx, ey, ly, tmin, tmax, th, t_n, t_mul;
	logic               okx, oky, fx, take;
	logic signed [31:0] dx2, dy2;
	logic signed [SW-1:0] sum_x, sum_y, plain_x, plain_y;

	always_comb begin
		rd_addr = j_q;
		if (op == scs_pkg::OP_RD_ID) rd_addr = id_q[IW-1:0];
	end

	always_ff @(posedge clk) begin
		if (op == scs_pkg::OP_CREATE)
			boxes[count_q[IW-1:0]] <= '{cx: px_q, cy: py_q, hw: hw_in_q, hh: hh_in_q};
		rd_q <= boxes[rd_addr];
	end

	// slab numerators relative to the current origin
	assign hx   = 32'(rd_q.hw) + 32'(mv_hw_q);
	assign hy   = 32'(rd_q.hh) + 32'(mv_hh_q);
	assign o_x  = NW'(ox_q);
	assign o_y  = NW'(oy_q);
	assign lo_x = NW'(rd_q.cx) - NW'(signed'({1'b0, hx}));
	assign hi_x = NW'(rd_q.cx) + NW'(signed'({1'b0, hx}));
	assign lo_y = NW'(rd_q.cy) - NW'(signed'({1'b0, hy}));
	assign hi_y = NW'(rd_q.cy) + NW'(signed'({1'b0, hy}));

	assign dv_start = (op == scs_pkg::OP_DIV_GO);

	scs_div u_div_lx (.clk, .arst_n, .start(dv_start), .num(nlo_x_q), .den(ddx_q),
		.done(dv_done[0]), .quo(q_lo_x));
	scs_div u_div_hx (.clk, .arst_n, .start(dv_start), .num(nhi_x_q), .den(ddx_q),
		.done(dv_done[1]), .quo(q_hi_x));
	scs_div u_div_ly (.clk, .arst_n, .start(dv_start), .num(nlo_y_q), .den(ddy_q),
		.done(dv_done[2]), .quo(q_lo_y));
	scs_div u_div_hy (.clk, .arst_n, .start(dv_start), .num(nhi_y_q), .den(ddy_q),
		.done(dv_done[3]), .quo(q_hi_y));

	always_comb begin
		sat_p = TW'(scs_pkg::TIME_SAT);
		sat_m = -TW'(scs_pkg::TIME_SAT);
		if (ddx_q == 32'sd0) begin
			okx = !(nlo_x_q > 0 || nhi_x_q < 0);
			ex  = sat_m;
			lx  = sat_p;
		end else begin
			okx = 1'b1;
			ex  = (q_lo_x < q_hi_x) ? q_lo_x : q_hi_x;
			lx  = (q_lo_x < q_hi_x) ? q_hi_x : q_lo_x;
		end
		if (ddy_q == 32'sd0) begin
			oky = !(nlo_y_q > 0 || nhi_y_q < 0);
			ey  = sat_m;
			ly  = sat_p;
		end else begin
			oky = 1'b1;
			ey  = (q_lo_y < q_hi_y) ? q_lo_y : q_hi_y;
			ly  = (q_lo_y < q_hi_y) ? q_hi_y : q_lo_y;
		end
		tmin = (ex >= ey) ? ex : ey;
		tmax = (lx <= ly) ? lx : ly;
		th   = (tmin < 0) ? tmax : tmin;
		fx   = (tmin < 0) ? (lx <= ly) : (ex >= ey);
		take = okx && oky && (j_q != id_q[IW-1:0]) && (tmax >= tmin) && (th >= 0)
			&& (th <= best_q);
	end

	assign t_n   = best_q + (inside_q ? TW'(scs_pkg::NUDGE) : -TW'(scs_pkg::NUDGE));
	assign t_mul = (op == scs_pkg::OP_MUL_N) ? t_n : TW'(scs_pkg::TIME_ONE) - best_q;
	assign sum_x = SW'(ox_q) + SW'(signed'(prod_x_q[MW-1:16]));
	assign sum_y = SW'(oy_q) + SW'(signed'(prod_y_q[MW-1:16]));
	assign plain_x = SW'(ox_q) + SW'(ddx_q);
	assign plain_y = SW'(oy_q) + SW'(ddy_q);
	assign dx2   = prod_x_q[47:16];
	assign dy2   = prod_y_q[47:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (op == scs_pkg::OP_CREATE) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			scs_pkg::OP_LOAD: begin
				req_q   <= req_type;
				id_q    <= collider_id;
				px_q    <= pos_x;
				py_q    <= pos_y;
				hw_in_q <= half_w;
				hh_in_q <= half_h;
				dx_q    <= delta_x;
				dy_q    <= delta_y;
			end
			scs_pkg::OP_CREATE, scs_pkg::OP_REJ_FULL, scs_pkg::OP_REJ_ID: begin
				status       <= (op == scs_pkg::OP_CREATE) ? scs_pkg::ST_OK :
					(op == scs_pkg::OP_REJ_FULL) ? scs_pkg::ST_FULL : scs_pkg::ST_BADID;
				new_id       <= (op == scs_pkg::OP_CREATE) ? 5'(count_q) : 5'd0;
				collided     <= 1'b0;
				inside_box   <= 1'b0;
				hit_id       <= 5'd0;
				hit_fraction <= 17'(scs_pkg::TIME_ONE);
				resolved_x   <= '0;
				resolved_y   <= '0;
			end
			scs_pkg::OP_LD_ID: begin
				mv_hw_q  <= rd_q.hw;
				mv_hh_q  <= rd_q.hh;
				ox_q     <= rd_q.cx;
				oy_q     <= rd_q.cy;
				ddx_q    <= dx_q;
				ddy_q    <= dy_q;
				best_q   <= TW'(scs_pkg::TIME_ONE);
				hit_q    <= 1'b0;
				inside_q <= 1'b0;
				facex_q  <= 1'b1;
				other_q  <= '0;
				pass2_q  <= 1'b0;
				j_q      <= '0;
			end
			scs_pkg::OP_CALC: begin
				nlo_x_q <= lo_x - o_x;
				nhi_x_q <= hi_x - o_x;
				nlo_y_q <= lo_y - o_y;
				nhi_y_q <= hi_y - o_y;
			end
			scs_pkg::OP_EVAL: begin
				if (take) begin
					best_q   <= th;
					hit_q    <= 1'b1;
					other_q  <= j_q;
					inside_q <= tmin < 0;
					facex_q  <= fx;
				end
				j_q <= j_q + IW'(1);
			end
			scs_pkg::OP_MUL_N, scs_pkg::OP_MUL_R: begin
				prod_x_q <= MW'(ddx_q) * MW'(t_mul);
				prod_y_q <= MW'(ddy_q) * MW'(t_mul);
			end
			scs_pkg::OP_RES: begin
				res_x_q <= scs_pkg::sat32(sum_x);
				res_y_q <= scs_pkg::sat32(sum_y);
			end
			scs_pkg::OP_SLIDE: begin
				ox_q       <= res_x_q;
				oy_q       <= res_y_q;
				ddx_q      <= facex_q ? 32'sd0 : dx2;
				ddy_q      <= facex_q ? dy2 : 32'sd0;
				p1_other_q <= other_q;
				pass2_q    <= 1'b1;
				best_q     <= TW'(scs_pkg::TIME_ONE);
				hit_q      <= 1'b0;
				inside_q   <= 1'b0;
				facex_q    <= 1'b1;
				other_q    <= '0;
				j_q        <= '0;
			end
			scs_pkg::OP_FIN: begin
				status     <= scs_pkg::ST_OK;
				new_id     <= 5'd0;
				collided   <= pass2_q;
				inside_box <= hit_q & inside_q;
				hit_id     <= hit_q ? 5'(other_q) : (pass2_q ? 5'(p1_other_q) : 5'd0);
				hit_fraction <= hit_q ? 17'(best_q) : 17'(scs_pkg::TIME_ONE);
				resolved_x <= hit_q ? res_x_q : scs_pkg::sat32(plain_x);
				resolved_y <= hit_q ? res_y_q : scs_pkg::sat32(plain_y);
			end
			default: begin
			end
		endcase
	end

	assign st.is_create = !req_q;
	assign st.full      = count_q >= CW'(scs_pkg::MAX_BOXES);
	assign st.id_bad    = CW'(id_q) >= count_q || 32'(id_q) >= scs_pkg::MAX_BOXES;
	assign st.div_done  = &dv_done;
	assign st.last_j    = (CW'(j_q) + CW'(1)) == count_q;
	assign st.hit       = hit_q;
	assign st.pass2     = pass2_q;

endmodule

// File: src/scs_ctrl.sv
// Controller for the swept box collision block: sequences create, rejects, the
// two sweep passes and result delivery. Depends on scs_pkg.
module scs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  scs_pkg::dp_status_t st,
	output scs_pkg::dp_op_t     op,
	output logic                busy,
	output logic                done
);

	scs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= scs_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		op      = scs_pkg::OP_NONE;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			scs_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					op      = scs_pkg::OP_LOAD;
					state_d = scs_pkg::S_DECODE;
				end
			end
			scs_pkg::S_DECODE: begin
				if (st.is_create) state_d = st.full ? scs_pkg::S_REJ_FULL : scs_pkg::S_CREATE;
				else              state_d = st.id_bad ? scs_pkg::S_REJ_ID : scs_pkg::S_RD_ID;
			end
			scs_pkg::S_CREATE: begin
				op      = scs_pkg::OP_CREATE;
				state_d = scs_pkg::S_DONE;
			end
			scs_pkg::S_REJ_FULL: begin
				op      = scs_pkg::OP_REJ_FULL;
				state_d = scs_pkg::S_DONE;
			end
			scs_pkg::S_REJ_ID: begin
				op      = scs_pkg::OP_REJ_ID;
				state_d = scs_pkg::S_DONE;
			end
			scs_pkg::S_RD_ID: begin
				op      = scs_pkg::OP_RD_ID;
				state_d = scs_pkg::S_LD_ID;
			end
			scs_pkg::S_LD_ID: begin
				op      = scs_pkg::OP_LD_ID;
				state_d = scs_pkg::S_RD_J;
			end
			scs_pkg::S_RD_J: begin
				op      = scs_pkg::OP_RD_J;
				state_d = scs_pkg::S_CALC;
			end
			scs_pkg::S_CALC: begin
				op      = scs_pkg::OP_CALC;
				state_d = scs_pkg::S_DGO;
			end
			scs_pkg::S_DGO: begin
				op      = scs_pkg::OP_DIV_GO;
				state_d = scs_pkg::S_DWAIT;
			end
			scs_pkg::S_DWAIT: begin
				if (st.div_done) state_d = scs_pkg::S_EVAL;
			end
			scs_pkg::S_EVAL: begin
				op = scs_pkg::OP_EVAL;
				if (!st.last_j) state_d = scs_pkg::S_RD_J;
				else            state_d = scs_pkg::S_MUL_N;
			end
			scs_pkg::S_MUL_N: begin
				// hit flag now includes the last box of the pass
				if (st.hit) begin
					op      = scs_pkg::OP_MUL_N;
					state_d = scs_pkg::S_RES;
				end else begin
					state_d = scs_pkg::S_FIN;
				end
			end
			scs_pkg::S_RES: begin
				op      = scs_pkg::OP_RES;
				state_d = st.pass2 ? scs_pkg::S_FIN : scs_pkg::S_MUL_R;
			end
			scs_pkg::S_MUL_R: begin
				op      = scs_pkg::OP_MUL_R;
				state_d = scs_pkg::S_SLIDE;
			end
			scs_pkg::S_SLIDE: begin
				op      = scs_pkg::OP_SLIDE;
				state_d = scs_pkg::S_RD_J;
			end
			scs_pkg::S_FIN: begin
				op      = scs_pkg::OP_FIN;
				state_d = scs_pkg::S_DONE;
			end
			scs_pkg::S_DONE: begin
				done    = 1'b1;
				state_d = scs_pkg::S_IDLE;
			end
			default: begin
				state_d = scs_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: src/swept_box_collision_slide.sv
// Swept box collision with one slide step. Create and rejected requests pass
// through DECODE, then CREATE or a reject state, then DONE. A move sweeps every
// stored box in one pass, and again in a second pass when it slides, paced
// by the 21-step slab dividers; one item at a time, result shown one cycle on done.
// arst_n clears the controller and the box count; the box table is not cleared.
// Depends on scs_pkg, scs_ctrl, scs_dp, scs_div.
module swept_box_collision_slide (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic               req_type,
	input  logic [4:0]         collider_id,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [30:0]        half_w,
	input  logic [30:0]        half_h,
	input  logic signed [31:0] delta_x,
	input  logic signed [31:0] delta_y,
	output logic [1:0]         status,
	output logic [4:0]         new_id,
	output logic               collided,
	output logic               inside_box,
	output logic [4:0]         hit_id,
	output logic [16:0]        hit_fraction,
	output logic signed [31:0] resolved_x,
	output logic signed [31:0] resolved_y
);

	scs_pkg::dp_op_t     op;
	scs_pkg::dp_status_t st;

	scs_ctrl u_ctrl (
		.clk, .arst_n, .start, .st, .op, .busy, .done
	);

	scs_dp u_dp (
		.clk, .arst_n, .op, .st,
		.req_type, .collider_id, .pos_x, .pos_y, .half_w, .half_h, .delta_x, .delta_y,
		.status, .new_id, .collided, .inside_box, .hit_id, .hit_fraction,
		.resolved_x, .resolved_y
	);

`ifndef SYNTHESIS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("item accepted but block not busy");
	a_no_hit_frac: assert property (@(posedge clk) disable iff (!arst_n)
		done && !collided |-> hit_fraction == 17'(scs_pkg::TIME_ONE))
		else $error("hit fraction set without a collision");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == scs_pkg::ST_OK || status == scs_pkg::ST_FULL
			|| status == scs_pkg::ST_BADID)) else $error("undefined status code");
`endif

endmodule
